FILE: rtl/dklru_pkg.sv
// shared types and constants for the dual key lru directory cache
// no dependencies
`default_nettype none
package dklru_pkg;

  localparam int SLOTS_DEF       = 32;
  localparam int HANDLE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF  = 16;

  localparam int CMD_W   = 3;
  localparam int KEY_W   = 64;
  localparam int FH_W    = 32;
  localparam int FC_W    = 16;
  localparam int SIDX_W  = 5;

  localparam logic [CMD_W-1:0] OP_GET_PATH = 3'd0;
  localparam logic [CMD_W-1:0] OP_GET_HNDL = 3'd1;
  localparam logic [CMD_W-1:0] OP_INV_PATH = 3'd2;
  localparam logic [CMD_W-1:0] OP_INV_HNDL = 3'd3;
  localparam logic [CMD_W-1:0] OP_FLUSH    = 3'd4;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
  } ctl_stat_t;

endpackage
`default_nettype wire

FILE: rtl/dklru_ctrl.sv
// request sequencer: accept, slot scan, commit, result hand-off
// depends on dklru_pkg
`default_nettype none
module dklru_ctrl import dklru_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CMD_W-1:0] cmd,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output ctl_cmd_t              ctl,
  input  wire ctl_stat_t        stat
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_WRITE = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state, state_next;
  logic       needs_scan;

  assign needs_scan = (cmd == OP_GET_PATH) || (cmd == OP_GET_HNDL) ||
                      (cmd == OP_INV_PATH) || (cmd == OP_INV_HNDL);

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = needs_scan ? ST_SCAN : ST_WRITE;
        end
      end
      ST_SCAN: begin
        ctl.issue = 1'b1;
        if (stat.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_WRITE;
      ST_WRITE: begin
        ctl.commit = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

FILE: rtl/dklru_dp.sv
// slot storage, valid bits, scan trackers, use counter and result register
// depends on dklru_pkg
`default_nettype none
module dklru_dp import dklru_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctl_cmd_t          ctl,
  output ctl_stat_t              stat,
  input  wire logic [CMD_W-1:0]  cmd,
  input  wire logic [KEY_W-1:0]  path_key,
  input  wire logic [KEY_W-1:0]  handle_key,
  input  wire logic [KEY_W-1:0]  dir_identity,
  input  wire logic              fill_ok,
  input  wire logic [FH_W-1:0]   fill_handle,
  input  wire logic [FC_W-1:0]   fill_count,
  output logic                   status,
  output logic                   hit,
  output logic [SIDX_W-1:0]      slot_index,
  output logic [FH_W-1:0]        entry_handle,
  output logic [FC_W-1:0]        entry_count
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int HW_IN = (HANDLE_BITS < FH_W) ? HANDLE_BITS : FH_W;
  localparam int CW_IN = (COUNT_BITS < FC_W) ? COUNT_BITS : FC_W;

  logic [KEY_W-1:0]       mem_pk [SLOTS];
  logic [KEY_W-1:0]       mem_hk [SLOTS];
  logic [KEY_W-1:0]       mem_id [SLOTS];
  logic [KEY_W-1:0]       mem_st [SLOTS];
  logic [HANDLE_BITS-1:0] mem_dh [SLOTS];
  logic [COUNT_BITS-1:0]  mem_dc [SLOTS];
  logic [SLOTS-1:0]       valid;

  logic [CMD_W-1:0]       op;
  logic [KEY_W-1:0]       pk, hk, ident;
  logic                   fok;
  logic [HANDLE_BITS-1:0] fh;
  logic [COUNT_BITS-1:0]  fc;
  logic [KEY_W-1:0]       use_counter;

  logic [IDX_W-1:0]       scan_addr;
  logic                   rd_en, rd_vbit;
  logic [IDX_W-1:0]       rd_idx;
  logic [KEY_W-1:0]       rd_pk, rd_hk, rd_id, rd_st;
  logic [HANDLE_BITS-1:0] rd_dh;
  logic [COUNT_BITS-1:0]  rd_dc;

  logic                   found_f, free_f;
  logic [IDX_W-1:0]       found_idx, free_idx, min_idx;
  logic [KEY_W-1:0]       f_pk, f_hk, f_id, min_st;
  logic [HANDLE_BITS-1:0] f_dh;
  logic [COUNT_BITS-1:0]  f_dc;

  logic                   by_path, is_get, is_inv;
  logic [KEY_W-1:0]       key, key_path, key_hndl;
  logic [KEY_W-1:0]       e_pk, e_hk, e_st;
  logic                   match, is_hit;
  logic [IDX_W-1:0]       pick;
  logic [KEY_W-1:0]       cnt_inc;

  assign stat.scan_last = (scan_addr == IDX_W'(SLOTS - 1));

  assign by_path  = (op == OP_GET_PATH) || (op == OP_INV_PATH);
  assign is_get   = (op == OP_GET_PATH) || (op == OP_GET_HNDL);
  assign is_inv   = (op == OP_INV_PATH) || (op == OP_INV_HNDL);
  assign key      = by_path ? pk : hk;
  assign key_path = by_path ? pk : '0;
  assign key_hndl = by_path ? '0 : hk;

  assign e_pk  = rd_vbit ? rd_pk : '0;
  assign e_hk  = rd_vbit ? rd_hk : '0;
  assign e_st  = rd_vbit ? rd_st : '0;
  assign match = rd_vbit && (key != '0) && ((by_path ? e_pk : e_hk) == key);

  assign is_hit  = found_f && (f_id == ident);
  assign cnt_inc = use_counter + KEY_W'(1);

  always_comb begin
    if (free_f && (!found_f || free_idx < found_idx)) pick = free_idx;
    else if (found_f)                                  pick = found_idx;
    else                                               pick = min_idx;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op    <= cmd;
      pk    <= path_key;
      hk    <= handle_key;
      ident <= dir_identity;
      fok   <= fill_ok;
      fh    <= HANDLE_BITS'(fill_handle[HW_IN-1:0]);
      fc    <= COUNT_BITS'(fill_count[CW_IN-1:0]);
    end
  end

  // scan read port
  always_ff @(posedge clk) begin
    rd_pk   <= mem_pk[scan_addr];
    rd_hk   <= mem_hk[scan_addr];
    rd_id   <= mem_id[scan_addr];
    rd_st   <= mem_st[scan_addr];
    rd_dh   <= mem_dh[scan_addr];
    rd_dc   <= mem_dc[scan_addr];
    rd_vbit <= valid[scan_addr];
    rd_idx  <= scan_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_en     <= 1'b0;
      scan_addr <= '0;
    end else begin
      rd_en <= ctl.issue;
      if (ctl.load)       scan_addr <= '0;
      else if (ctl.issue) scan_addr <= scan_addr + IDX_W'(1);
    end
  end

  // scan trackers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      found_f <= 1'b0;
      free_f  <= 1'b0;
    end else if (rd_en) begin
      if (match && !found_f) begin
        found_f   <= 1'b1;
        found_idx <= rd_idx;
        f_pk      <= e_pk;
        f_hk      <= e_hk;
        f_id      <= rd_id;
        f_dh      <= rd_dh;
        f_dc      <= rd_dc;
      end
      if (!rd_vbit && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= rd_idx;
      end
      if (rd_idx == '0 || e_st < min_st) begin
        min_st  <= e_st;
        min_idx <= rd_idx;
      end
    end
  end

  // slot write port
  always_ff @(posedge clk) begin
    if (ctl.commit && is_get) begin
      if (is_hit) begin
        mem_st[found_idx] <= cnt_inc;
        mem_pk[found_idx] <= (key_path != '0 && f_pk == '0) ? key_path : f_pk;
        mem_hk[found_idx] <= (key_hndl != '0 && f_hk == '0) ? key_hndl : f_hk;
      end else if (fok) begin
        mem_pk[pick] <= key_path;
        mem_hk[pick] <= key_hndl;
        mem_id[pick] <= ident;
        mem_st[pick] <= '0;
        mem_dh[pick] <= fh;
        mem_dc[pick] <= fc;
      end
    end
  end

  // valid bits, use counter and result
  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      use_counter <= '0;
    end else if (ctl.commit) begin
      if (op == OP_FLUSH) begin
        valid <= '0;
      end else if (is_inv) begin
        if (found_f) valid[found_idx] <= 1'b0;
      end else if (is_get) begin
        if (is_hit) begin
          use_counter <= cnt_inc;
        end else begin
          if (found_f) valid[found_idx] <= 1'b0;
          valid[pick] <= fok;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      status       <= 1'b0;
      hit          <= 1'b0;
      slot_index   <= '0;
      entry_handle <= '0;
      entry_count  <= '0;
      if (is_inv && found_f) begin
        hit        <= 1'b1;
        slot_index <= SIDX_W'(found_idx);
      end else if (is_get) begin
        if (is_hit) begin
          hit          <= 1'b1;
          slot_index   <= SIDX_W'(found_idx);
          entry_handle <= FH_W'(f_dh[HW_IN-1:0]);
          entry_count  <= FC_W'(f_dc[CW_IN-1:0]);
        end else begin
          slot_index <= SIDX_W'(pick);
          if (fok) begin
            entry_handle <= FH_W'(fh[HW_IN-1:0]);
            entry_count  <= FC_W'(fc[CW_IN-1:0]);
          end else begin
            status <= 1'b1;
          end
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> !(status && hit)) else $error("hit reported with error");
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && op == OP_FLUSH |=> valid == '0) else $error("flush left valid slots");
  a_hit_stays: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && is_get && is_hit |=> valid[$past(found_idx)])
    else $error("hit slot lost valid");
  a_fail_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.commit && is_get && !is_hit && !fok |=> !valid[$past(pick)])
    else $error("failed fill left slot valid");
`endif

endmodule
`default_nettype wire

FILE: rtl/dual_key_lru_dir_cache.sv
// get and invalidate raise the result after one full pass over the slot store through its
// single read port, then the drain, write and output states; flush and unused commands skip the
// scan and go from the write state to the output state. one request at a time: a new request
// is taken only once the result has been taken with out_ready
// reset (rst, synchronous) clears all valid bits and the use counter
// depends on dklru_pkg, dklru_ctrl, dklru_dp
`default_nettype none
module dual_key_lru_dir_cache import dklru_pkg::*; #(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CMD_W-1:0]  cmd,
  input  wire logic [KEY_W-1:0]  path_key,
  input  wire logic [KEY_W-1:0]  handle_key,
  input  wire logic [KEY_W-1:0]  dir_identity,
  input  wire logic              fill_ok,
  input  wire logic [FH_W-1:0]   fill_handle,
  input  wire logic [FC_W-1:0]   fill_count,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   status,
  output logic                   hit,
  output logic [SIDX_W-1:0]      slot_index,
  output logic [FH_W-1:0]        entry_handle,
  output logic [FC_W-1:0]        entry_count
);

  ctl_cmd_t  ctl;
  ctl_stat_t stat;

  dklru_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .cmd, .out_valid, .out_ready,
    .ctl, .stat
  );

  dklru_dp #(
    .SLOTS(SLOTS), .HANDLE_BITS(HANDLE_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk, .rst, .ctl, .stat, .cmd, .path_key, .handle_key, .dir_identity,
    .fill_ok, .fill_handle, .fill_count, .status, .hit, .slot_index,
    .entry_handle, .entry_count
  );

endmodule
`default_nettype wire
